[src/pot_pkg.sv]
// Shared types, constants and fixed-point helpers for the polyline offset block.
`timescale 1ns / 1ps
`default_nettype none
package pot_pkg;

    localparam int unsigned MAX_POINTS_DEF = 65536;
    localparam logic [30:0] THICK_RST      = 31'd65536;
    localparam logic        REG_THICKNESS  = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_MSQX, S_MSQY, S_SQINIT, S_SQRT,
        S_TXSET, S_TXDIV, S_TYSET, S_TYDIV, S_TEND,
        S_DOTX, S_DOTY, S_DEN, S_ADIV, S_MOX, S_MOY, S_MOE,
        S_MP, S_MA, S_MD, S_FORM, S_EMIT
    } t_state;

    typedef struct packed {
        logic               side;
        logic [15:0]        idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               run_end;
    } t_result;

    // Q16.16 product back to Q16.16, round half up
    function automatic logic signed [47:0] rq16(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return 48'(s >>> 16);
    endfunction

    // base +/- offset, saturated to signed 32 bits
    function automatic logic [31:0] vtx(input logic signed [31:0] base,
                                        input logic signed [47:0] off,
                                        input logic               neg);
        logic signed [49:0] s;
        s = neg ? (50'(base) - 50'(off)) : (50'(base) + 50'(off));
        if (s > 50'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (s < -50'sd2147483648)
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

endpackage
`default_nettype wire

[src/polyline_offset_thicken.sv]
// Polyline offset: miter joins and square caps around a streamed polyline.
// A non-first point is handled by a 32-step square root, up to three restoring divisions
// sharing one divider (the angle division only on a later segment) and one shared 32x32
// multiplier.
// Throughput: one point at a time; ready is low from acceptance until the last
// result (0, 2 or 4 per point) is taken. A lone point's results follow its DIFF state.
// Reset (synchronous, active low) clears held point, tangent, count; thickness to default.
`timescale 1ns / 1ps
`default_nettype none
module polyline_offset_thicken #(
    parameter int unsigned MAX_POINTS = pot_pkg::MAX_POINTS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // point requests
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_x,
    input  wire signed [31:0]  i_y,
    input  wire                i_last_point,
    // vertex results
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_side,
    output logic [15:0]        o_point_index,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_run_end,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_POINTS);
    localparam logic signed [32:0] LIM = 33'sh0_8000_0000;

    pot_pkg::t_state r_state, n_state;

    logic [30:0]        r_thick;
    logic signed [31:0] r_held_x, r_held_y, r_px, r_py, r_dx, r_dy;
    logic signed [17:0] r_tpx, r_tpy, r_tcx, r_tcy;
    logic [CW-1:0]      r_count, r_cur;
    logic               r_have, r_last, r_neg, r_zlen, r_aovf;
    logic signed [63:0] r_prod, r_acc;
    logic [63:0]        r_rad, r_root, r_num;
    logic [4:0]         r_it, r_dcnt;
    logic [31:0]        r_rem, r_den;
    logic [30:0]        r_quo;
    logic signed [47:0] r_ox, r_oy, r_p, r_a;
    pot_pkg::t_result   r_res [4];
    logic [2:0]         r_nres;
    logic [1:0]         r_oidx;

    // ---------------- combinational helpers ----------------
    logic [29:0]        w_h;
    logic signed [47:0] w_hoff;
    logic signed [32:0] w_dx33, w_dy33;
    logic               w_big;
    logic [CW:0]        w_cur;
    logic               w_force;
    logic [63:0]        w_b, w_rb;
    logic               w_sq_ge;
    logic [32:0]        w_rem2;
    logic               w_dv_ge;
    logic [32:0]        w_dv_sub;
    logic [31:0]        w_adx, w_ady;
    logic [63:0]        w_xnum, w_ynum, w_anum;
    logic signed [17:0] w_tq;
    logic signed [63:0] w_dsum;
    logic signed [47:0] w_dot, w_denr;
    logic [31:0]        w_den;
    logic [30:0]        w_alpha;
    logic signed [18:0] w_sxx, w_syy, w_cpm, w_cmp, w_cpp;
    logic signed [31:0] w_ma, w_mb;
    logic signed [47:0] w_d;
    logic [CW+15:0]     w_cnt_ext, w_cur_ext;

    assign w_h     = r_thick[30:1];
    assign w_hoff  = {18'b0, w_h};
    assign w_dx33  = 33'(r_px) - 33'(r_held_x);
    assign w_dy33  = 33'(r_py) - 33'(r_held_y);
    assign w_big   = (w_dx33 >= LIM) || (w_dx33 <= -LIM) ||
                     (w_dy33 >= LIM) || (w_dy33 <= -LIM);
    assign w_cur   = {1'b0, r_count} + (CW+1)'(1);
    assign w_force = w_cur >= (CW+1)'(MAX_POINTS - 1);

    // square root digit step
    assign w_b     = 64'h4000_0000_0000_0000 >> {r_it, 1'b0};
    assign w_rb    = r_root + w_b;
    assign w_sq_ge = r_rad >= w_rb;

    // restoring divider step
    assign w_rem2   = {r_rem, r_num[63]};
    assign w_dv_sub = w_rem2 - {1'b0, r_den};
    assign w_dv_ge  = w_rem2 >= {1'b0, r_den};

    assign w_adx  = r_dx[31] ? 32'(-33'(r_dx)) : r_dx;
    assign w_ady  = r_dy[31] ? 32'(-33'(r_dy)) : r_dy;
    assign w_xnum = {16'b0, w_adx, 16'b0};
    assign w_ynum = {16'b0, w_ady, 16'b0};
    assign w_anum = {18'b0, w_h, 16'b0};
    assign w_tq   = r_neg ? -$signed({1'b0, r_quo[16:0]}) : $signed({1'b0, r_quo[16:0]});

    assign w_dsum = r_acc + r_prod;
    assign w_dot  = 48'(w_dsum >>> 16);
    assign w_denr = 48'sd65536 + w_dot;
    assign w_den  = (w_denr < 48'sd1) ? 32'd1 : w_denr[31:0];
    assign w_alpha = r_aovf ? 31'h7FFF_FFFF : r_quo;

    assign w_sxx = 19'(r_tcx) + 19'(r_tpx);
    assign w_syy = 19'(r_tcy) + 19'(r_tpy);
    assign w_cpp = 19'(r_tcx) + 19'(r_tcy);
    assign w_cpm = 19'(r_tcx) - 19'(r_tcy);
    assign w_cmp = 19'(r_tcy) - 19'(r_tcx);
    assign w_d   = pot_pkg::rq16(r_prod);

    assign w_cnt_ext = (CW+16)'(r_count);
    assign w_cur_ext = (CW+16)'(w_cur[CW-1:0]);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            pot_pkg::S_IDLE:   if (i_valid) n_state = pot_pkg::S_DIFF;
            pot_pkg::S_DIFF: begin
                if (!r_have)
                    n_state = r_last ? pot_pkg::S_EMIT : pot_pkg::S_IDLE;
                else
                    n_state = pot_pkg::S_MSQX;
            end
            pot_pkg::S_MSQX:   n_state = pot_pkg::S_MSQY;
            pot_pkg::S_MSQY:   n_state = pot_pkg::S_SQINIT;
            pot_pkg::S_SQINIT: n_state = pot_pkg::S_SQRT;
            pot_pkg::S_SQRT:   if (r_it == 5'd31) n_state = pot_pkg::S_TXSET;
            pot_pkg::S_TXSET:
                n_state = (r_root == 64'd0) ? pot_pkg::S_TEND : pot_pkg::S_TXDIV;
            pot_pkg::S_TXDIV:  if (r_dcnt == 5'd1) n_state = pot_pkg::S_TYSET;
            pot_pkg::S_TYSET:  n_state = pot_pkg::S_TYDIV;
            pot_pkg::S_TYDIV:  if (r_dcnt == 5'd1) n_state = pot_pkg::S_TEND;
            pot_pkg::S_TEND:
                n_state = (r_count == '0) ? pot_pkg::S_MP : pot_pkg::S_DOTX;
            pot_pkg::S_DOTX:   n_state = pot_pkg::S_DOTY;
            pot_pkg::S_DOTY:   n_state = pot_pkg::S_DEN;
            pot_pkg::S_DEN:    n_state = pot_pkg::S_ADIV;
            pot_pkg::S_ADIV:   if (r_dcnt == 5'd1) n_state = pot_pkg::S_MOX;
            pot_pkg::S_MOX:    n_state = pot_pkg::S_MOY;
            pot_pkg::S_MOY:    n_state = pot_pkg::S_MOE;
            pot_pkg::S_MOE:    n_state = r_last ? pot_pkg::S_MP : pot_pkg::S_FORM;
            pot_pkg::S_MP:     n_state = pot_pkg::S_MA;
            pot_pkg::S_MA:     n_state = pot_pkg::S_MD;
            pot_pkg::S_MD:     n_state = pot_pkg::S_FORM;
            pot_pkg::S_FORM:   n_state = pot_pkg::S_EMIT;
            pot_pkg::S_EMIT:
                if (i_ready && (3'(r_oidx) + 3'd1 == r_nres)) n_state = pot_pkg::S_IDLE;
            default:           n_state = pot_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs and multiplier operands ----------------
    always_comb begin
        o_ready = (r_state == pot_pkg::S_IDLE);
        o_valid = (r_state == pot_pkg::S_EMIT);
        w_ma    = '0;
        w_mb    = '0;
        case (r_state)
            pot_pkg::S_MSQX: begin w_ma = r_dx;                w_mb = r_dx;        end
            pot_pkg::S_MSQY: begin w_ma = r_dy;                w_mb = r_dy;        end
            pot_pkg::S_DOTX: begin w_ma = 32'(r_tcx);          w_mb = 32'(r_tpx);  end
            pot_pkg::S_DOTY: begin w_ma = 32'(r_tcy);          w_mb = 32'(r_tpy);  end
            pot_pkg::S_MOX:  begin w_ma = {1'b0, w_alpha};     w_mb = 32'(w_syy);  end
            pot_pkg::S_MOY:  begin w_ma = {1'b0, w_alpha};     w_mb = 32'(w_sxx);  end
            pot_pkg::S_MP:   begin w_ma = {2'b0, w_h};         w_mb = 32'(w_cpp);  end
            pot_pkg::S_MA:   begin w_ma = {2'b0, w_h};         w_mb = 32'(w_cpm);  end
            pot_pkg::S_MD:   begin w_ma = {2'b0, w_h};         w_mb = 32'(w_cmp);  end
            default:         begin w_ma = '0;                  w_mb = '0;          end
        endcase
    end

    assign o_side        = r_res[r_oidx].side;
    assign o_point_index = r_res[r_oidx].idx;
    assign o_out_x       = r_res[r_oidx].x;
    assign o_out_y       = r_res[r_oidx].y;
    assign o_run_end     = r_res[r_oidx].run_end;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pot_pkg::REG_THICKNESS) ? {1'b0, r_thick} : 32'd0;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pot_pkg::S_IDLE;
            r_thick  <= pot_pkg::THICK_RST;
            r_have   <= 1'b0;
            r_count  <= '0;
            r_held_x <= '0;
            r_held_y <= '0;
            r_tpx    <= '0;
            r_tpy    <= '0;
            r_oidx   <= '0;
            r_nres   <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == pot_pkg::REG_THICKNESS)
                r_thick <= pwdata[30:0];
            case (r_state)
                pot_pkg::S_DIFF: begin
                    r_oidx <= '0;
                    if (!r_have) begin
                        if (r_last) begin
                            r_nres <= 3'd4;
                        end else begin
                            r_held_x <= r_px;
                            r_held_y <= r_py;
                            r_count  <= '0;
                            r_have   <= 1'b1;
                        end
                    end
                end
                pot_pkg::S_FORM: begin
                    r_oidx <= '0;
                    r_nres <= r_last ? 3'd4 : 3'd2;
                    if (r_last) begin
                        r_have   <= 1'b0;
                        r_count  <= '0;
                        r_held_x <= '0;
                        r_held_y <= '0;
                        r_tpx    <= '0;
                        r_tpy    <= '0;
                    end else begin
                        r_held_x <= r_px;
                        r_held_y <= r_py;
                        r_tpx    <= r_tcx;
                        r_tpy    <= r_tcy;
                        r_count  <= r_cur;
                    end
                end
                pot_pkg::S_EMIT: if (i_ready) r_oidx <= r_oidx + 2'd1;
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            pot_pkg::S_IDLE: begin
                r_px   <= i_x;
                r_py   <= i_y;
                r_last <= i_last_point;
            end
            pot_pkg::S_DIFF: begin
                r_dx  <= w_big ? w_dx33[32:1] : w_dx33[31:0];
                r_dy  <= w_big ? w_dy33[32:1] : w_dy33[31:0];
                r_cur <= w_cur[CW-1:0];
                if (r_have && w_force) r_last <= 1'b1;
                // lone point: box corners
                r_res[0] <= '{1'b0, 16'd0, pot_pkg::vtx(r_px, w_hoff, 1'b1),
                               pot_pkg::vtx(r_py, w_hoff, 1'b1), 1'b0};
                r_res[1] <= '{1'b0, 16'd0, pot_pkg::vtx(r_px, w_hoff, 1'b0),
                               pot_pkg::vtx(r_py, w_hoff, 1'b1), 1'b0};
                r_res[2] <= '{1'b1, 16'd0, pot_pkg::vtx(r_px, w_hoff, 1'b0),
                               pot_pkg::vtx(r_py, w_hoff, 1'b0), 1'b0};
                r_res[3] <= '{1'b1, 16'd0, pot_pkg::vtx(r_px, w_hoff, 1'b1),
                               pot_pkg::vtx(r_py, w_hoff, 1'b0), 1'b1};
            end
            pot_pkg::S_MSQY:   r_rad <= 64'(r_prod);
            pot_pkg::S_SQINIT: begin
                r_rad  <= r_rad + 64'(r_prod);
                r_root <= '0;
                r_it   <= '0;
            end
            pot_pkg::S_SQRT: begin
                if (w_sq_ge) begin
                    r_rad  <= r_rad - w_rb;
                    r_root <= (r_root >> 1) + w_b;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_it <= r_it + 5'd1;
            end
            pot_pkg::S_TXSET: begin
                r_zlen <= (r_root == 64'd0);
                r_tcx  <= '0;
                r_neg  <= r_dx[31];
                r_den  <= r_root[31:0];
                r_rem  <= 32'(w_xnum >> 17);
                r_num  <= w_xnum << 47;
                r_dcnt <= 5'd17;
                r_quo  <= '0;
            end
            pot_pkg::S_TXDIV, pot_pkg::S_TYDIV, pot_pkg::S_ADIV: begin
                r_rem  <= w_dv_ge ? w_dv_sub[31:0] : w_rem2[31:0];
                r_num  <= r_num << 1;
                r_quo  <= {r_quo[29:0], w_dv_ge};
                r_dcnt <= r_dcnt - 5'd1;
            end
            pot_pkg::S_TYSET: begin
                r_tcx  <= w_tq;
                r_neg  <= r_dy[31];
                r_rem  <= 32'(w_ynum >> 17);
                r_num  <= w_ynum << 47;
                r_dcnt <= 5'd17;
                r_quo  <= '0;
            end
            pot_pkg::S_TEND:   r_tcy <= r_zlen ? 18'sd0 : w_tq;
            pot_pkg::S_DOTY:   r_acc <= r_prod;
            pot_pkg::S_DEN: begin
                r_den  <= w_den;
                r_aovf <= (w_anum >> 31) >= 64'(w_den);
                r_rem  <= 32'(w_anum >> 31);
                r_num  <= w_anum << 33;
                r_dcnt <= 5'd31;
                r_quo  <= '0;
            end
            pot_pkg::S_MOY:    r_ox <= w_d;
            pot_pkg::S_MOE:    r_oy <= w_d;
            pot_pkg::S_MA:     r_p  <= w_d;
            pot_pkg::S_MD:     r_a  <= w_d;
            pot_pkg::S_FORM: begin
                if (r_count == '0) begin
                    r_res[0] <= '{1'b0, 16'd0, pot_pkg::vtx(r_held_x, r_a, 1'b1),
                                   pot_pkg::vtx(r_held_y, r_p, 1'b1), 1'b0};
                    r_res[1] <= '{1'b1, 16'd0, pot_pkg::vtx(r_held_x, r_p, 1'b1),
                                   pot_pkg::vtx(r_held_y, w_d, 1'b1), 1'b0};
                end else begin
                    r_res[0] <= '{1'b0, w_cnt_ext[15:0], pot_pkg::vtx(r_held_x, r_ox, 1'b0),
                                   pot_pkg::vtx(r_held_y, r_oy, 1'b1), 1'b0};
                    r_res[1] <= '{1'b1, w_cnt_ext[15:0], pot_pkg::vtx(r_held_x, r_ox, 1'b1),
                                   pot_pkg::vtx(r_held_y, r_oy, 1'b0), 1'b0};
                end
                r_res[2] <= '{1'b0, w_cur_ext[15:0], pot_pkg::vtx(r_px, r_p, 1'b0),
                               pot_pkg::vtx(r_py, w_d, 1'b0), 1'b0};
                r_res[3] <= '{1'b1, w_cur_ext[15:0], pot_pkg::vtx(r_px, r_a, 1'b0),
                               pot_pkg::vtx(r_py, r_p, 1'b0), 1'b1};
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_oidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (3'(r_oidx) < r_nres))
        else $error("result index past result count");

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end) |-> (3'(r_oidx) + 3'd1 == r_nres))
        else $error("run end flagged before the final result");

    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_run_end) |=> o_ready)
        else $error("block not ready after closing a polyline");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> ({1'b0, r_count} <= (CW+1)'(MAX_POINTS - 2)))
        else $error("held point index reached the point limit");

endmodule
`default_nettype wire

[tb/sv/polyline_offset_thicken_checker.sv]
// Checker for the polyline offset block: predicts vertices and compares results.
`timescale 1ns / 1ps
module polyline_offset_thicken_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               o_ready,
    input  wire signed [31:0] i_x,
    input  wire signed [31:0] i_y,
    input  wire               i_last_point,
    input  wire               o_valid,
    input  wire               i_ready,
    input  wire               o_side,
    input  wire [15:0]        o_point_index,
    input  wire signed [31:0] o_out_x,
    input  wire signed [31:0] o_out_y,
    input  wire               o_run_end,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    input  wire               pready,
    output int                o_errors,
    output int                o_pending
);

    pot_pkg::t_result vertex_q[$];

    logic [30:0] thick;
    logic        have_pt;
    int          held_px, held_py;
    int          tan_px, tan_py;
    int unsigned pt_cnt;

    initial o_errors = 0;
    assign o_pending = vertex_q.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    task automatic unit_dir(input longint dx, input longint dy, output int tx, output int ty);
        longint          lim;
        longint unsigned len;
        lim = 64'sd1 << 31;
        if (dx >= lim || dx <= -lim || dy >= lim || dy <= -lim) begin
            dx = dx >>> 1;
            dy = dy >>> 1;
        end
        len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        if (len == 0) begin
            tx = 0;
            ty = 0;
        end else begin
            tx = int'((dx * 65536) / longint'(len));
            ty = int'((dy * 65536) / longint'(len));
        end
    endtask

    task automatic push_vertex(input logic side, input int unsigned idx,
                               input longint vx, input longint vy, input logic fin);
        pot_pkg::t_result r;
        r.side    = side;
        r.idx     = idx[15:0];
        r.x       = clamp32(vx);
        r.y       = clamp32(vy);
        r.run_end = fin;
        vertex_q.push_back(r);
    endtask

    task automatic predict_vertices(input int px_i, input int py_i, input logic last_in);
        longint      px, py, h, hx, hy, dot, den, alpha, ox, oy;
        int          tcx, tcy;
        int unsigned cur;
        logic        last;
        px   = px_i;
        py   = py_i;
        last = last_in;
        h    = longint'(thick >> 1);
        if (!have_pt) begin
            if (last) begin
                push_vertex(1'b0, 0, px - h, py - h, 1'b0);
                push_vertex(1'b0, 0, px + h, py - h, 1'b0);
                push_vertex(1'b1, 0, px + h, py + h, 1'b0);
                push_vertex(1'b1, 0, px - h, py + h, 1'b1);
            end else begin
                held_px = px_i;
                held_py = py_i;
                pt_cnt  = 0;
                have_pt = 1'b1;
            end
        end else begin
            hx  = held_px;
            hy  = held_py;
            cur = pt_cnt + 1;
            if (cur >= pot_pkg::MAX_POINTS_DEF - 1) last = 1'b1;
            unit_dir(px - hx, py - hy, tcx, tcy);
            if (pt_cnt == 0) begin
                push_vertex(1'b0, 0, hx - round_q16(h * (tcx - tcy)),
                            hy - round_q16(h * (tcy + tcx)), 1'b0);
                push_vertex(1'b1, 0, hx - round_q16(h * (tcx + tcy)),
                            hy - round_q16(h * (tcy - tcx)), 1'b0);
            end else begin
                dot = (longint'(tcx) * tan_px + longint'(tcy) * tan_py) >>> 16;
                den = 65536 + dot;
                if (den < 1) den = 1;
                alpha = (h * 65536) / den;
                if (alpha > 64'sd2147483647) alpha = 64'sd2147483647;
                ox = round_q16(alpha * (longint'(tcy) + tan_py));
                oy = round_q16(alpha * (longint'(tcx) + tan_px));
                push_vertex(1'b0, pt_cnt, hx + ox, hy - oy, 1'b0);
                push_vertex(1'b1, pt_cnt, hx - ox, hy + oy, 1'b0);
            end
            if (last) begin
                push_vertex(1'b0, cur, px + round_q16(h * (tcx + tcy)),
                            py + round_q16(h * (tcy - tcx)), 1'b0);
                push_vertex(1'b1, cur, px + round_q16(h * (tcx - tcy)),
                            py + round_q16(h * (tcy + tcx)), 1'b1);
                have_pt = 1'b0;
                pt_cnt  = 0;
                held_px = 0;
                held_py = 0;
                tan_px  = 0;
                tan_py  = 0;
            end else begin
                held_px = px_i;
                held_py = py_i;
                tan_px  = tcx;
                tan_py  = tcy;
                pt_cnt  = cur;
            end
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        pot_pkg::t_result e;
        if (!i_rst_n) begin
            thick   = pot_pkg::THICK_RST;
            have_pt = 1'b0;
            held_px = 0;
            held_py = 0;
            tan_px  = 0;
            tan_py  = 0;
            pt_cnt  = 0;
            vertex_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == pot_pkg::REG_THICKNESS)
                thick = pwdata[30:0];
            // results first: a result taken at this edge belongs to an older request
            if (o_valid && i_ready) begin
                if (vertex_q.size() == 0) begin
                    report("unexpected result, index", o_point_index, -1);
                end else begin
                    e = vertex_q.pop_front();
                    if (o_side != e.side) report("side", o_side, e.side);
                    if (o_point_index != e.idx) report("point_index", o_point_index, e.idx);
                    if (o_out_x != e.x) report("out_x", o_out_x, e.x);
                    if (o_out_y != e.y) report("out_y", o_out_y, e.y);
                    if (o_run_end != e.run_end) report("run_end", o_run_end, e.run_end);
                end
            end
            if (i_valid && o_ready)
                predict_vertices(i_x, i_y, i_last_point);
        end
    end

endmodule

[tb/sv/polyline_offset_thicken_test.sv]
// Top of the polyline offset testbench: clock, reset, requests, config and verdict.
`timescale 1ns / 1ps
module polyline_offset_thicken_test;

    localparam int CYCLE_LIMIT = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_x;
    logic signed [31:0] i_y;
    logic               i_last_point;
    logic               o_valid;
    logic               i_ready;
    logic               o_side;
    logic [15:0]        o_point_index;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_run_end;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int pending;
    int sent_points;
    int burst_left;
    logic hold_off;

    polyline_offset_thicken dut (.*);

    polyline_offset_thicken_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_x, .i_y, .i_last_point,
        .o_valid, .i_ready, .o_side, .o_point_index, .o_out_x, .o_out_y,
        .o_run_end, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: pattern changes every so often, long hold-off forced once
    initial begin
        int mode, left;
        i_ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            if (hold_off)       i_ready <= 1'b0;
            else if (mode == 0) i_ready <= 1'b1;
            else if (mode == 1) i_ready <= ($urandom_range(0, 1) == 1);
            else if (mode == 2) i_ready <= ($urandom_range(0, 3) == 0);
            else                i_ready <= ($urandom_range(0, 7) != 0);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (sent_points >= 120);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_x          <= x;
        i_y          <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (!o_ready);
        sent_points++;
    endtask

    // quiet period: zero-result requests can still be in flight
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (160) @(negedge i_clk);
    endtask

    task automatic write_thickness(input logic [30:0] value);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {pot_pkg::REG_THICKNESS, 2'b00};
        pwdata  <= {1'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(input int scale);
        case (scale)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
            default: return 32'($signed($urandom_range(0, 2 * 65536 * 4096)) - 65536 * 4096);
        endcase
    endfunction

    task automatic random_polyline();
        int          len, scale;
        logic [31:0] x, y;
        len   = $urandom_range(1, 8);
        scale = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        x = rand_coord(scale);
        y = rand_coord(scale);
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 9) != 0) begin
                // mostly a short step from the last point, sometimes a repeat
                if ($urandom_range(0, 12) != 0) begin
                    x = x + 32'($signed($urandom_range(0, 65536 * 512)) - 65536 * 256);
                    y = y + 32'($signed($urandom_range(0, 65536 * 512)) - 65536 * 256);
                end
            end else if (k > 0) begin
                x = $urandom;
                y = $urandom;
            end
            send_point(x, y, k == len - 1);
        end
    endtask

    task automatic directed_set();
        send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h0, 32'h0, 1'b1);
        // full-range segment forces the halving of the difference
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // straight, right angle, then doubling back
        send_point(32'h0, 32'h0, 1'b0);
        send_point(32'h000A_0000, 32'h0, 1'b0);
        send_point(32'h0014_0000, 32'h0, 1'b0);
        send_point(32'h0014_0000, 32'h000A_0000, 1'b0);
        send_point(32'h0014_0000, 32'h0, 1'b1);
        // coincident points
        send_point(32'h0005_0000, 32'h0005_0000, 1'b0);
        send_point(32'h0005_0000, 32'h0005_0000, 1'b0);
        send_point(32'h0009_0000, 32'h0005_0000, 1'b0);
        send_point(32'h0009_0000, 32'h0005_0000, 1'b1);
        // near the edge of the range, offsets saturate
        send_point(32'h7FFF_0000, 32'h8000_1000, 1'b0);
        send_point(32'h7FFF_F000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_0000, 32'h8000_0000, 1'b1);
    endtask

    initial begin
        int total;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_x          = '0;
        i_y          = '0;
        i_last_point = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sent_points  = 0;
        burst_left   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_set();
        write_thickness(31'd0);
        directed_set();
        write_thickness(31'h7FFF_FFFF);
        directed_set();
        write_thickness(31'h0004_0000);

        total = sent_points + 230;
        while (sent_points < total) begin
            random_polyline();
            if ($urandom_range(0, 40) == 0) begin
                while (sent_points >= 0 && $urandom_range(0, 1) == 1)
                    random_polyline();
                write_thickness(31'($urandom_range(0, 32'h7FFF_FFFF)));
            end
        end
        write_thickness(31'd1);
        directed_set();

        settle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
